/* hdl/g711fc_pkg.sv */
// Package for the G.711 / PCM16 format converter: format codes and sample conversion functions.
`timescale 1ns / 1ps

package g711fc_pkg;

  // Configuration register indexes.
  localparam logic REG_DIRECTION = 1'b0;
  localparam logic REG_FORMAT    = 1'b1;

  // Direction register values.
  localparam logic DIR_TO_S16   = 1'b0;
  localparam logic DIR_FROM_S16 = 1'b1;

  // Sample format register values.
  localparam logic [2:0] FMT_U8      = 3'd0;
  localparam logic [2:0] FMT_NATIVE  = 3'd1;
  localparam logic [2:0] FMT_SWAPPED = 3'd2;
  localparam logic [2:0] FMT_ALAW    = 3'd3;
  localparam logic [2:0] FMT_ULAW    = 3'd4;

  localparam logic [7:0]  ALAW_MASK_POS = 8'hD5;
  localparam logic [7:0]  ALAW_MASK_NEG = 8'h55;
  localparam logic [7:0]  ULAW_MASK_POS = 8'hFF;
  localparam logic [7:0]  ULAW_MASK_NEG = 8'h7F;
  localparam logic [7:0]  LAW_END_CODE  = 8'h7F;
  localparam logic [13:0] ULAW_CLIP     = 14'd8159;
  localparam logic [13:0] ULAW_BIAS14   = 14'd33;
  localparam logic [15:0] ULAW_BIAS16   = 16'h0084;

  typedef struct packed {
    logic        dir;
    logic [2:0]  fmt;
  } cfg_t;

  function automatic logic [15:0] swap16(input logic [15:0] s);
    return {s[7:0], s[15:8]};
  endfunction

  // A-law encode of the s16 sample taken as a 13-bit linear value.
  function automatic logic [7:0] alaw_encode(input logic [15:0] s);
    logic [7:0]  mask;
    logic [11:0] mag;
    logic [2:0]  seg;
    logic [3:0]  mant;
    mask = s[15] ? ALAW_MASK_NEG : ALAW_MASK_POS;
    // For negative samples the one's complement gives -(x>>3)-1.
    mag  = s[15] ? ~s[14:3] : s[14:3];
    if (mag[11])      seg = 3'd7;
    else if (mag[10]) seg = 3'd6;
    else if (mag[9])  seg = 3'd5;
    else if (mag[8])  seg = 3'd4;
    else if (mag[7])  seg = 3'd3;
    else if (mag[6])  seg = 3'd2;
    else if (mag[5])  seg = 3'd1;
    else              seg = 3'd0;
    if (seg < 3'd2) begin
      mant = mag[4:1];
    end else begin
      mant = 4'(mag >> seg);
    end
    return {1'b0, seg, mant} ^ mask;
  endfunction

  // Mu-law encode of the s16 sample taken as a 14-bit linear value.
  function automatic logic [7:0] ulaw_encode(input logic [15:0] s);
    logic [7:0]  mask;
    logic [16:0] neg;
    logic [14:0] mag;
    logic [13:0] biased;
    logic [2:0]  seg;
    logic [3:0]  mant;
    neg  = 17'h10000 - {1'b0, s} + 17'd3;
    mask = s[15] ? ULAW_MASK_NEG : ULAW_MASK_POS;
    mag  = s[15] ? neg[16:2] : {2'b00, s[15:3]} << 1 | {14'd0, s[2]};
    if (mag > {1'b0, ULAW_CLIP}) begin
      biased = ULAW_CLIP + ULAW_BIAS14;
    end else begin
      biased = mag[13:0] + ULAW_BIAS14;
    end
    if (biased[12])     seg = 3'd7;
    else if (biased[11]) seg = 3'd6;
    else if (biased[10]) seg = 3'd5;
    else if (biased[9])  seg = 3'd4;
    else if (biased[8])  seg = 3'd3;
    else if (biased[7])  seg = 3'd2;
    else if (biased[6])  seg = 3'd1;
    else                 seg = 3'd0;
    mant = 4'(biased >> ({1'b0, seg} + 4'd1));
    // The clip level plus bias lands just past the top segment.
    if (biased[13]) begin
      return LAW_END_CODE ^ mask;
    end
    return {1'b0, seg, mant} ^ mask;
  endfunction

  function automatic logic [15:0] alaw_decode(input logic [7:0] c);
    logic [7:0]  a;
    logic [2:0]  seg;
    logic [15:0] t;
    a   = c ^ ALAW_MASK_NEG;
    seg = a[6:4];
    if (seg == 3'd0) begin
      t = {8'd0, a[3:0], 4'h8};
    end else begin
      t = {7'd0, 1'b1, a[3:0], 4'h8};
      if (seg > 3'd1) begin
        t = t << (seg - 3'd1);
      end
    end
    return a[7] ? t : 16'(16'd0 - t);
  endfunction

  function automatic logic [15:0] ulaw_decode(input logic [7:0] c);
    logic [7:0]  u;
    logic [15:0] t;
    u = ~c;
    t = (16'({u[3:0], 3'b000}) + ULAW_BIAS16) << u[6:4];
    return u[7] ? 16'(ULAW_BIAS16 - t) : 16'(t - ULAW_BIAS16);
  endfunction

  // One sample through the configured conversion.
  function automatic logic [15:0] convert(input cfg_t cfg, input logic [15:0] s);
    logic [15:0] r;
    r = s;
    if (cfg.dir == DIR_TO_S16) begin
      case (cfg.fmt)
        FMT_U8:      r = {~s[7], s[6:0], 8'h00};
        FMT_SWAPPED: r = swap16(s);
        FMT_ALAW:    r = alaw_decode(s[7:0]);
        FMT_ULAW:    r = ulaw_decode(s[7:0]);
        default:     r = s;
      endcase
    end else begin
      case (cfg.fmt)
        FMT_U8:      r = {8'h00, ~s[15], s[14:8]};
        FMT_SWAPPED: r = swap16(s);
        FMT_ALAW:    r = {8'h00, alaw_encode(s)};
        FMT_ULAW:    r = {8'h00, ulaw_encode(s)};
        default:     r = s;
      endcase
    end
    return r;
  endfunction

endpackage

/* hdl/g711_pcm16_format_converter_core.sv */
// Top level of the G.711 / PCM16 sample format converter.
`timescale 1ns / 1ps

// Converts one audio sample per item between signed 16-bit PCM and a
// configured format: unsigned 8-bit, native 16-bit, byte-swapped 16-bit,
// G.711 A-law or G.711 mu-law. The direction register picks decoding into
// s16 (0) or encoding from s16 (1); sample_format picks the format.
// Input items arrive on the in_ stream channel and results leave on the
// out_ stream channel; tlast is carried along with its sample unchanged.
// Eight-bit codes sit in the low byte of tdata with the high byte zero.
// An accepted item is held in an input register, converted by a short
// combinational path, and lands in the output register, which drives
// out_tvalid and out_tdata. Both stages move together, so while the
// receiver keeps out_tready high one item is taken and one result given
// every cycle, as long as the sender keeps offering items.
// When the receiver stalls, the output register holds its result and the
// input register still takes one more item; ready toward the sender drops
// only once both stages are full. Reset clears both valid bits and sets
// both configuration registers to zero (u8 decoding). Configuration is
// written through cfg_we/cfg_index/cfg_wdata while the stream is idle.
module g711_pcm16_format_converter_core (
  input  logic        clk,
  input  logic        rst_n,
  // Input stream.
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [15:0] in_tdata,   // [15:0] sample_in
  input  logic        in_tlast,   // last_in
  // Result stream.
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,  // [15:0] sample_out
  output logic        out_tlast,  // last_out
  // Configuration write port.
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [2:0]  cfg_wdata
);

  g711fc_pkg::cfg_t cfg_r;

  logic        in_valid_r;
  logic [15:0] in_sample_r;
  logic        in_last_r;

  logic        out_valid_r;
  logic [15:0] out_sample_r;
  logic        out_last_r;

  logic        out_free;
  logic        advance;
  logic [15:0] result_nxt;

  // The output register can load when it is empty or being drained.
  assign out_free  = !out_valid_r || out_tready;
  assign advance   = in_valid_r && out_free;
  assign in_tready = !in_valid_r || out_free;

  assign result_nxt = g711fc_pkg::convert(cfg_r, in_sample_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r       <= '0;
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          g711fc_pkg::REG_DIRECTION: cfg_r.dir <= cfg_wdata[0];
          g711fc_pkg::REG_FORMAT:    cfg_r.fmt <= cfg_wdata;
          default:                   cfg_r     <= cfg_r;
        endcase
      end
      if (in_tready) begin
        in_valid_r <= in_tvalid;
      end
      if (out_free) begin
        out_valid_r <= in_valid_r;
      end
    end
  end

  // Payload registers need no reset.
  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      in_sample_r <= in_tdata;
      in_last_r   <= in_tlast;
    end
    if (advance) begin
      out_sample_r <= result_nxt;
      out_last_r   <= in_last_r;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_sample_r;
  assign out_tlast  = out_last_r;

endmodule

/* tb/tb_top.sv */
// Self-checking testbench for the G.711 / PCM16 sample format converter core.
`timescale 1ns / 1ps

// The run walks through a series of configuration phases covering both
// directions and every value of the 3-bit format register, the undefined
// codes among them. Each phase starts with a few directed samples (full
// scale, zero, all ones, the mu-law clip point, codes with a dirty high
// byte) followed by random samples whose magnitudes are spread over all
// G.711 segments.
//
// A driver process feeds the input channel from a queue that the main
// initial block fills. For every accepted item the driver computes the
// expected sample with a local behavioral model and appends it to the
// queue of awaited results. A monitor process pulls results off the output
// channel and compares sample and last flag against the oldest entry.
// Both sides idle at random, except in two calm phases. In two other phases
// the receiver holds off for a long stretch so that the core backs up and
// drops in_tready. A watchdog ends the run if nothing moves for too long.
module tb_top;

  // Format codes that the core does not define; samples pass through.
  localparam logic [2:0] FMT_SPARE_5 = 3'd5;
  localparam logic [2:0] FMT_SPARE_6 = 3'd6;
  localparam logic [2:0] FMT_SPARE_7 = 3'd7;

  // Direction register words; the dirty ones carry junk in the upper bits.
  localparam logic [2:0] DEC_WORD       = {2'b00, g711fc_pkg::DIR_TO_S16};
  localparam logic [2:0] ENC_WORD       = {2'b00, g711fc_pkg::DIR_FROM_S16};
  localparam logic [2:0] DEC_WORD_DIRTY = {2'b11, g711fc_pkg::DIR_TO_S16};
  localparam logic [2:0] ENC_WORD_DIRTY = {2'b11, g711fc_pkg::DIR_FROM_S16};

  localparam int NUM_PHASES     = 14;
  localparam int RANDOM_PER_PH  = 60;
  localparam int HOLD_OFF_LEN   = 60;
  localparam int QUIET_LIMIT    = 2000;
  localparam int DRAIN_CYCLES   = 10;
  localparam int IDLE_PERCENT   = 23;
  localparam int REPORT_LIMIT   = 10;

  typedef struct packed {
    logic [15:0] sample;
    logic        last;
  } pcm_item_t;

  logic        clk;
  logic        rst_n      = 1'b0;
  logic        in_tvalid  = 1'b0;
  logic        in_tready;
  logic [15:0] in_tdata   = 16'h0000;
  logic        in_tlast   = 1'b0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [15:0] out_tdata;
  logic        out_tlast;
  logic        cfg_we     = 1'b0;
  logic        cfg_index  = g711fc_pkg::REG_DIRECTION;
  logic [2:0]  cfg_wdata  = 3'd0;

  // Testbench copy of the configuration, starting from the reset values.
  logic        dir_shadow = g711fc_pkg::DIR_TO_S16;
  logic [2:0]  fmt_shadow = g711fc_pkg::FMT_U8;

  pcm_item_t   outgoing[$];   // samples waiting to be offered
  pcm_item_t   awaited[$];    // converted samples not yet seen on the output

  bit          calm        = 1'b0;  // no idling on either side
  bit          squeeze_req = 1'b0;  // asks the receiver for a long hold-off
  int          hold_left   = 0;
  int          quiet_cycles = 0;
  int          mismatch_count = 0;

  g711_pcm16_format_converter_core uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // ---------------------------------------------------------------------
  // Behavioral model of the conversions.
  // ---------------------------------------------------------------------

  // A-law code of an s16 sample seen as a 13-bit linear value. Negative
  // samples use the one's complement, which gives -(x>>3)-1.
  function automatic logic [7:0] alaw_from_linear(input logic [15:0] s);
    int unsigned mag;
    int unsigned seg;
    int unsigned code;
    logic [15:0] inv;
    logic [7:0]  flip;
    inv = ~s;
    if (s[15]) begin
      flip = 8'h55;
      mag  = inv >> 3;
    end else begin
      flip = 8'hD5;
      mag  = s >> 3;
    end
    seg = 0;
    while (seg < 8 && mag > (32'h20 << seg) - 1) seg++;
    if (seg >= 8) return 8'h7F ^ flip;
    code = seg << 4;
    if (seg < 2) code = code | ((mag >> 1) & 32'hF);
    else code = code | ((mag >> seg) & 32'hF);
    return 8'(code) ^ flip;
  endfunction

  // Mu-law code of an s16 sample seen as a 14-bit linear value. Magnitudes
  // beyond the G.711 clip level saturate, and the biased clip level falls
  // past the top segment, which yields the end code.
  function automatic logic [7:0] ulaw_from_linear(input logic [15:0] s);
    int unsigned mag;
    int unsigned seg;
    int unsigned code;
    logic [7:0]  flip;
    if (s[15]) begin
      flip = 8'h7F;
      mag  = ((32'h10000 - s) + 3) >> 2;
    end else begin
      flip = 8'hFF;
      mag  = s >> 2;
    end
    if (mag > 8159) mag = 8159;
    mag = mag + 33;
    seg = 0;
    while (seg < 8 && mag > (32'h40 << seg) - 1) seg++;
    if (seg >= 8) return 8'h7F ^ flip;
    code = (seg << 4) | ((mag >> (seg + 1)) & 32'hF);
    return 8'(code) ^ flip;
  endfunction

  function automatic logic [15:0] linear_from_alaw(input logic [7:0] c);
    logic [7:0]  a;
    int unsigned t;
    int unsigned seg;
    a   = c ^ 8'h55;
    t   = 32'(a[3:0]) << 4;
    seg = a[6:4];
    if (seg == 0) begin
      t = t + 8;
    end else begin
      t = t + 32'h108;
      if (seg > 1) t = t << (seg - 1);
    end
    return a[7] ? 16'(t) : 16'(0 - t);
  endfunction

  function automatic logic [15:0] linear_from_ulaw(input logic [7:0] c);
    logic [7:0]  u;
    int unsigned t;
    u = ~c;
    t = ((32'(u[3:0]) << 3) + 32'h84) << u[6:4];
    return u[7] ? 16'(32'h84 - t) : 16'(t - 32'h84);
  endfunction

  // Result word for one sample under the given configuration. Eight-bit
  // codes go out in the low byte with the high byte zero, and eight-bit
  // inputs ignore the high byte of the sample.
  function automatic logic [15:0] converted_word(input logic dir, input logic [2:0] fmt,
                                                 input logic [15:0] s);
    logic [15:0] r;
    r = s;
    if (dir == g711fc_pkg::DIR_TO_S16) begin
      case (fmt)
        g711fc_pkg::FMT_U8:      r = 16'((32'(s[7:0]) + 32'hFF80) << 8);
        g711fc_pkg::FMT_SWAPPED: r = {s[7:0], s[15:8]};
        g711fc_pkg::FMT_ALAW:    r = linear_from_alaw(s[7:0]);
        g711fc_pkg::FMT_ULAW:    r = linear_from_ulaw(s[7:0]);
        default:                 r = s;
      endcase
    end else begin
      case (fmt)
        g711fc_pkg::FMT_U8:      r = {8'h00, 8'(s[15:8] + 8'h80)};
        g711fc_pkg::FMT_SWAPPED: r = {s[7:0], s[15:8]};
        g711fc_pkg::FMT_ALAW:    r = {8'h00, alaw_from_linear(s)};
        g711fc_pkg::FMT_ULAW:    r = {8'h00, ulaw_from_linear(s)};
        default:                 r = s;
      endcase
    end
    return r;
  endfunction

  // ---------------------------------------------------------------------
  // Input driver. An item stays on the bus until it is accepted; only
  // between items may the driver insert an idle cycle.
  // ---------------------------------------------------------------------
  always @(posedge clk) begin
    pcm_item_t want;
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else begin
      if (in_tvalid && in_tready) begin
        want.sample = converted_word(dir_shadow, fmt_shadow, in_tdata);
        want.last   = in_tlast;
        awaited.push_back(want);
        void'(outgoing.pop_front());
      end
      if (!in_tvalid || in_tready) begin
        if (outgoing.size() != 0 && (calm || $urandom_range(99) >= IDLE_PERCENT)) begin
          in_tvalid <= 1'b1;
          in_tdata  <= outgoing[0].sample;
          in_tlast  <= outgoing[0].last;
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  task automatic report_fault(input string what, input logic [15:0] want,
                              input logic [15:0] got);
    mismatch_count++;
    if (mismatch_count <= REPORT_LIMIT)
      $display("%0t: %s: expected %h, got %h", $realtime, what, want, got);
  endtask

  // ---------------------------------------------------------------------
  // Result monitor and receiver back-pressure.
  // ---------------------------------------------------------------------
  always @(posedge clk) begin
    pcm_item_t want;
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (out_tvalid && out_tready) begin
        if (awaited.size() == 0) begin
          report_fault("result with nothing pending", 16'h0000, out_tdata);
        end else begin
          want = awaited.pop_front();
          if (out_tdata !== want.sample)
            report_fault("sample_out", want.sample, out_tdata);
          if (out_tlast !== want.last)
            report_fault("last_out", 16'(want.last), 16'(out_tlast));
        end
      end
      // A long hold-off lets the sender fill both pipeline stages.
      if (squeeze_req) begin
        squeeze_req = 1'b0;
        hold_left   = HOLD_OFF_LEN;
      end
      if (hold_left != 0) begin
        hold_left--;
        out_tready <= 1'b0;
      end else begin
        out_tready <= calm || ($urandom_range(99) >= IDLE_PERCENT);
      end
    end
  end

  // Watchdog: ends the run when no item moves and no register is written.
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || cfg_we || !rst_n) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // One register write; the task raises cfg_we and drops it again once the core has sampled the write.
  task automatic write_register(input logic idx, input logic [2:0] value);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == g711fc_pkg::REG_DIRECTION) dir_shadow = value[0];
    else fmt_shadow = value;
  endtask

  task automatic offer(input logic [15:0] s, input logic l);
    pcm_item_t item;
    item.sample = s;
    item.last   = l;
    outgoing.push_back(item);
  endtask

  // Random sample: a random word shifted arithmetically by a random amount,
  // so that small magnitudes of both signs (low segments) show up often.
  function automatic logic [15:0] random_sample();
    logic [15:0] raw;
    raw = 16'($urandom_range(65535));
    return 16'($signed(raw) >>> $urandom_range(15));
  endfunction

  // ---------------------------------------------------------------------
  // Stimulus sequence.
  // ---------------------------------------------------------------------
  initial begin
    logic [2:0] dir_word;
    logic [2:0] fmt_word;
    bit         encoding;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      // Phase 0 runs on the reset configuration. The direction register is
      // sometimes written with upper bits set, which the core must drop.
      dir_word = DEC_WORD;
      fmt_word = g711fc_pkg::FMT_U8;
      case (ph)
        1:  begin dir_word = ENC_WORD;       fmt_word = g711fc_pkg::FMT_U8;      end
        2:  begin dir_word = DEC_WORD;       fmt_word = g711fc_pkg::FMT_NATIVE;  end
        3:  begin dir_word = ENC_WORD_DIRTY; fmt_word = g711fc_pkg::FMT_NATIVE;  end
        4:  begin dir_word = DEC_WORD;       fmt_word = g711fc_pkg::FMT_SWAPPED; end
        5:  begin dir_word = ENC_WORD;       fmt_word = g711fc_pkg::FMT_SWAPPED; end
        6:  begin dir_word = DEC_WORD;       fmt_word = g711fc_pkg::FMT_ALAW;    end
        7:  begin dir_word = ENC_WORD;       fmt_word = g711fc_pkg::FMT_ALAW;    end
        8:  begin dir_word = DEC_WORD_DIRTY; fmt_word = g711fc_pkg::FMT_ULAW;    end
        9:  begin dir_word = ENC_WORD;       fmt_word = g711fc_pkg::FMT_ULAW;    end
        10: begin dir_word = DEC_WORD;       fmt_word = FMT_SPARE_5;             end
        11: begin dir_word = ENC_WORD;       fmt_word = FMT_SPARE_6;             end
        12: begin dir_word = DEC_WORD;       fmt_word = FMT_SPARE_7;             end
        13: begin dir_word = ENC_WORD;       fmt_word = FMT_SPARE_7;             end
        default: ;
      endcase
      if (ph != 0) begin
        write_register(g711fc_pkg::REG_DIRECTION, dir_word);
        write_register(g711fc_pkg::REG_FORMAT, fmt_word);
      end

      @(negedge clk);
      calm        = (ph == 2 || ph == 3);
      squeeze_req = (ph == 5 || ph == 9);
      encoding    = (dir_shadow == g711fc_pkg::DIR_FROM_S16);

      // Directed samples: one marker word for the undefined formats, full scale for
      // the eight-bit encoders, zero and all ones otherwise, last flag set on the final one.
      if (fmt_shadow > g711fc_pkg::FMT_ULAW) begin
        offer(16'hA55A, 1'b1);
      end else if (encoding && fmt_shadow != g711fc_pkg::FMT_NATIVE &&
                   fmt_shadow != g711fc_pkg::FMT_SWAPPED) begin
        offer(16'h7FFF, 1'b0);
        offer(16'h8000, 1'b1);
      end else begin
        offer(16'h0000, 1'b0);
        offer(16'hFFFF, 1'b1);
      end
      // Mu-law encode right at and just past the clip level.
      if (encoding && fmt_shadow == g711fc_pkg::FMT_ULAW) begin
        offer(16'h7F7C, 1'b0);
        offer(16'h7F80, 1'b0);
      end
      // Decoders must ignore a dirty high byte.
      if (!encoding && (fmt_shadow == g711fc_pkg::FMT_ALAW ||
                        fmt_shadow == g711fc_pkg::FMT_ULAW))
        offer(16'hFF55, 1'b0);

      for (int i = 0; i < RANDOM_PER_PH; i++)
        offer(random_sample(), $urandom_range(7) == 0);

      // Configuration may only change once the pipeline has drained.
      while (outgoing.size() != 0 || awaited.size() != 0) @(posedge clk);
    end

    // Give any spurious extra result time to show up.
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
